FILE: rtl/tcw_pkg.sv
// Shared constants, types and helper functions for the text console writer.
package tcw_pkg;

  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 8;

  localparam int CELLS     = ROWS * COLUMNS;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int TOP_W     = $clog2(ROWS);
  localparam int TAB_STOPS = (COLUMNS - 1) / TAB_WIDTH + 1;

  localparam int OP_W   = 3;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;

  localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

  typedef enum logic [OP_W-1:0] {
    OP_PUT        = 3'd0,
    OP_PUT_COLOR  = 3'd1,
    OP_CLEAR      = 3'd2,
    OP_SET_CURSOR = 3'd3,
    OP_READ       = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_IDLE,
    ST_READ
  } state_t;

  // Outcome of putting one character at the current cursor.
  typedef struct packed {
    logic              wr_en;
    logic [ROW_W-1:0]  wr_row;
    logic [COL_W-1:0]  wr_col;
    logic [CELL_W-1:0] wr_data;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              scroll;
  } put_res_t;

  function automatic logic [CELL_W-1:0] make_cell(input logic [ATTR_W-1:0] attr,
                                                  input logic [CHAR_W-1:0] ch);
    return {attr, ch};
  endfunction

  // Smallest multiple of TAB_WIDTH above col.
  function automatic logic [7:0] tab_stop(input logic [COL_W-1:0] col);
    logic [7:0] res;
    res = 8'(TAB_STOPS * TAB_WIDTH);
    for (int k = TAB_STOPS - 1; k >= 1; k--) begin
      if (8'(k * TAB_WIDTH) > {1'b0, col}) begin
        res = 8'(k * TAB_WIDTH);
      end
    end
    return res;
  endfunction

  // Logical row is rotated by the top-row offset to get the stored row.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col,
                                                  input logic [TOP_W-1:0] top);
    logic [ROW_W:0] phys;
    phys = (ROW_W+1)'(row) + (ROW_W+1)'(top);
    if (phys >= (ROW_W+1)'(ROWS)) begin
      phys = phys - (ROW_W+1)'(ROWS);
    end
    return ADDR_W'(phys) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

FILE: rtl/tcw_chan_if.sv
// Valid/ready channel interfaces for the console's input and result items.
interface tcw_in_if;
  logic                      valid;
  logic                      ready;
  logic [tcw_pkg::OP_W-1:0]   operation;
  logic [tcw_pkg::CHAR_W-1:0] char_code;
  logic [tcw_pkg::ATTR_W-1:0] color_override;
  logic [tcw_pkg::ROW_W-1:0]  target_row;
  logic [tcw_pkg::COL_W-1:0]  target_col;

  modport source (output valid, operation, char_code, color_override, target_row,
                  target_col, input ready);
  modport sink (input valid, operation, char_code, color_override, target_row,
                target_col, output ready);
endinterface

interface tcw_out_if;
  logic                      valid;
  logic                      ready;
  logic [tcw_pkg::ROW_W-1:0]  cursor_row;
  logic [tcw_pkg::COL_W-1:0]  cursor_col;
  logic [tcw_pkg::POS_W-1:0]  cursor_position;
  logic [tcw_pkg::CELL_W-1:0] cell_value;
  logic                      scrolled;

  modport source (output valid, cursor_row, cursor_col, cursor_position, cell_value,
                  scrolled, input ready);
  modport sink (input valid, cursor_row, cursor_col, cursor_position, cell_value,
                scrolled, output ready);
endinterface

FILE: rtl/text_console_writer_unit.sv
// Text console top level: cell memory, cursor, row rotation and block sweeps.
// Results: put, set-cursor, clear and no-op items give their result in the cycle after
// acceptance, a cell read after its memory read in ST_READ. One item per cycle otherwise,
// while the result side takes results; a cell read holds off the input in ST_READ.
// A scroll then blanks the old top row, a clear blanks all ROWS*COLUMNS cells;
// no item is accepted during either sweep (single write port of the cell memory).
// Reset: synchronous active-low; a clearing pass over all ROWS*COLUMNS cells follows.
module text_console_writer_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  tcw_in_if.sink                     in_if,
  tcw_out_if.source                  out_if,
  input  logic                       cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata
);

  localparam int AW = tcw_pkg::ADDR_W;
  localparam int TW = tcw_pkg::TOP_W;

  tcw_pkg::state_t state_r, state_nxt;

  logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELLS];
  logic [tcw_pkg::CELL_W-1:0] rdata_r;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata;
  logic [AW-1:0]              mem_raddr;

  logic [AW-1:0]              sweep_addr_r;
  logic [AW-1:0]              sweep_end_r;
  logic [tcw_pkg::ATTR_W-1:0] fill_attr_r;
  logic [tcw_pkg::ATTR_W-1:0] default_attr_r;
  logic [TW-1:0]              top_r;
  logic [tcw_pkg::ROW_W-1:0]  row_r;
  logic [tcw_pkg::COL_W-1:0]  col_r;

  logic                       out_valid_r;
  logic [tcw_pkg::ROW_W-1:0]  out_row_r;
  logic [tcw_pkg::COL_W-1:0]  out_col_r;
  logic [tcw_pkg::POS_W-1:0]  out_pos_r;
  logic [tcw_pkg::CELL_W-1:0] out_cell_r;
  logic                       out_scroll_r;

  logic                       accept;
  tcw_pkg::op_t               op;
  logic                       is_put;
  logic [tcw_pkg::ATTR_W-1:0] put_attr;
  logic [tcw_pkg::ROW_W-1:0]  tr;
  logic [tcw_pkg::COL_W-1:0]  tc;
  logic [tcw_pkg::ROW_W-1:0]  row_nxt;
  logic [tcw_pkg::COL_W-1:0]  col_nxt;
  logic                       scroll_nxt;
  logic [AW-1:0]              lin_pos;
  tcw_pkg::put_res_t          pr;

  assign in_if.ready = (state_r == tcw_pkg::ST_IDLE) && (!out_valid_r || out_if.ready);
  assign accept      = in_if.valid && in_if.ready;
  assign op          = tcw_pkg::op_t'(in_if.operation);
  assign is_put      = (op == tcw_pkg::OP_PUT) || (op == tcw_pkg::OP_PUT_COLOR);
  assign put_attr    = (op == tcw_pkg::OP_PUT_COLOR) ? in_if.color_override : default_attr_r;

  assign tr = (in_if.target_row > tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) ?
              tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1) : in_if.target_row;
  assign tc = (in_if.target_col > tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1)) ?
              tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1) : in_if.target_col;

  tcw_put_logic u_put (
    .row       (row_r),
    .col       (col_r),
    .char_code (in_if.char_code),
    .attr      (put_attr),
    .res       (pr)
  );

  // Cursor after the item
  always_comb begin
    row_nxt    = row_r;
    col_nxt    = col_r;
    scroll_nxt = 1'b0;
    unique case (op)
      tcw_pkg::OP_PUT, tcw_pkg::OP_PUT_COLOR: begin
        row_nxt    = pr.row;
        col_nxt    = pr.col;
        scroll_nxt = pr.scroll;
      end
      tcw_pkg::OP_CLEAR: begin
        row_nxt = '0;
        col_nxt = '0;
      end
      tcw_pkg::OP_SET_CURSOR: begin
        row_nxt = tr;
        col_nxt = tc;
      end
      default: begin
      end
    endcase
  end

  assign lin_pos = AW'(row_nxt) * AW'(tcw_pkg::COLUMNS) + AW'(col_nxt);

  // Memory port selection: sweeps own the write port, else a put writes its cell
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_addr_r;
    mem_wdata = tcw_pkg::make_cell(fill_attr_r, tcw_pkg::BLANK_CHAR);
    if (state_r == tcw_pkg::ST_FILL) begin
      mem_we = 1'b1;
    end else if (accept && is_put && pr.wr_en) begin
      mem_we    = 1'b1;
      mem_waddr = tcw_pkg::cell_addr(pr.wr_row, pr.wr_col, top_r);
      mem_wdata = pr.wr_data;
    end
  end

  assign mem_raddr = tcw_pkg::cell_addr(tr, tc, top_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcw_pkg::ST_FILL: begin
        if (sweep_addr_r == sweep_end_r) begin
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          if (op == tcw_pkg::OP_READ) begin
            state_nxt = tcw_pkg::ST_READ;
          end else if ((op == tcw_pkg::OP_CLEAR) || (is_put && pr.scroll)) begin
            state_nxt = tcw_pkg::ST_FILL;
          end
        end
      end
      tcw_pkg::ST_READ: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= tcw_pkg::ST_FILL;
      sweep_addr_r   <= '0;
      sweep_end_r    <= AW'(tcw_pkg::CELLS - 1);
      fill_attr_r    <= tcw_pkg::RESET_ATTR;
      default_attr_r <= tcw_pkg::RESET_ATTR;
      top_r          <= '0;
      row_r          <= '0;
      col_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        default_attr_r <= cfg_wdata;
      end
      if (state_r == tcw_pkg::ST_FILL) begin
        sweep_addr_r <= sweep_addr_r + 1'b1;
      end
      // an accept implies any earlier result is gone; a read's result goes valid from ST_READ
      if (state_r == tcw_pkg::ST_READ) begin
        out_valid_r <= 1'b1;
      end else if (accept) begin
        out_valid_r <= (op != tcw_pkg::OP_READ);
      end else if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
        if (op == tcw_pkg::OP_CLEAR) begin
          top_r        <= '0;
          sweep_addr_r <= '0;
          sweep_end_r  <= AW'(tcw_pkg::CELLS - 1);
          fill_attr_r  <= default_attr_r;
        end else if (is_put && pr.scroll) begin
          // old top row becomes the new bottom row; blank it
          sweep_addr_r <= AW'(top_r) * AW'(tcw_pkg::COLUMNS);
          sweep_end_r  <= AW'(top_r) * AW'(tcw_pkg::COLUMNS) + AW'(tcw_pkg::COLUMNS - 1);
          fill_attr_r  <= put_attr;
          top_r        <= (top_r == TW'(tcw_pkg::ROWS - 1)) ? '0 : top_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_row_r    <= row_nxt;
      out_col_r    <= col_nxt;
      out_pos_r    <= tcw_pkg::POS_W'(lin_pos);
      out_cell_r   <= '0;
      out_scroll_r <= scroll_nxt;
    end else if (state_r == tcw_pkg::ST_READ) begin
      out_cell_r <= rdata_r;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.cursor_row      = out_row_r;
  assign out_if.cursor_col      = out_col_r;
  assign out_if.cursor_position = out_pos_r;
  assign out_if.cell_value      = out_cell_r;
  assign out_if.scrolled        = out_scroll_r;

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(row_r) < tcw_pkg::ROWS) && (32'(col_r) < tcw_pkg::COLUMNS))
    else $error("cursor outside the screen");

  a_clear_homes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (op == tcw_pkg::OP_CLEAR)) |=>
      (state_r == tcw_pkg::ST_FILL) && (row_r == '0) && (col_r == '0) &&
      (sweep_addr_r == '0))
    else $error("clear did not home the cursor and start a full sweep");

  a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (op == tcw_pkg::OP_READ)) |=> (state_r == tcw_pkg::ST_READ) && !out_valid_r)
    else $error("cell read result shown before memory data");

  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcw_pkg::ST_FILL) |-> (sweep_addr_r <= sweep_end_r))
    else $error("blanking sweep ran past its end");

endmodule

FILE: rtl/tcw_put_logic.sv
// Character interpretation: control codes, cursor advance, wrap and scroll detect.
module tcw_put_logic (
  input  logic [tcw_pkg::ROW_W-1:0]  row,
  input  logic [tcw_pkg::COL_W-1:0]  col,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code,
  input  logic [tcw_pkg::ATTR_W-1:0] attr,
  output tcw_pkg::put_res_t          res
);

  logic [tcw_pkg::ROW_W:0] r;
  logic [7:0]              c;

  always_comb begin
    res         = '0;
    res.wr_row  = row;
    res.wr_col  = col;
    res.wr_data = tcw_pkg::make_cell(attr, char_code);
    r = (tcw_pkg::ROW_W+1)'(row);
    c = 8'(col);
    unique case (char_code)
      tcw_pkg::CH_LF: begin
        c = '0;
        r = r + 1'b1;
      end
      tcw_pkg::CH_CR: begin
        c = '0;
      end
      tcw_pkg::CH_TAB: begin
        c = tcw_pkg::tab_stop(col);
      end
      tcw_pkg::CH_BS: begin
        if (col != '0) begin
          c           = 8'(col) - 1'b1;
          res.wr_en   = 1'b1;
          res.wr_col  = col - 1'b1;
          res.wr_data = tcw_pkg::make_cell(attr, tcw_pkg::BLANK_CHAR);
        end
      end
      default: begin
        res.wr_en = 1'b1;
        c         = 8'(col) + 1'b1;
      end
    endcase
    if (c >= 8'(tcw_pkg::COLUMNS)) begin
      c = '0;
      r = r + 1'b1;
    end
    if (r >= (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS)) begin
      r          = (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS - 1);
      res.scroll = 1'b1;
    end
    res.row = r[tcw_pkg::ROW_W-1:0];
    res.col = c[tcw_pkg::COL_W-1:0];
  end

endmodule

FILE: bench/tcw_console_checker.sv
// Console checker: tracks screen and cursor from accepted items and compares every result.
`timescale 1ns / 1ps

module tcw_console_checker
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  tcw_in_if                 in_ch,
  tcw_out_if                out_ch,
  input  logic              cfg_we,
  input  logic [ATTR_W-1:0] cfg_wdata,
  output int                mismatch_count,
  output int                pending_results
);

  typedef struct {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [POS_W-1:0]  pos;
    logic [CELL_W-1:0] cell_val;
    logic              scrolled;
  } cursor_report_t;

  logic [CELL_W-1:0] screen_mem [CELLS];
  int unsigned       cur_row;
  int unsigned       cur_col;
  logic [ATTR_W-1:0] active_attr;
  cursor_report_t    expected_reports [$];
  int                mismatches_seen = 0;

  function automatic int unsigned slot_of(int unsigned r, int unsigned c);
    int unsigned idx;
    idx = r * COLUMNS + c;
    return (idx < CELLS) ? idx : CELLS - 1;
  endfunction

  function automatic void blank_range(int unsigned from, int unsigned upto,
                                      logic [ATTR_W-1:0] attr);
    for (int unsigned i = from; i < upto && i < CELLS; i++) begin
      screen_mem[i] = {attr, BLANK_CHAR};
    end
  endfunction

  // Returns 1 when the put pushed the cursor below the last row.
  function automatic bit put_glyph(logic [CHAR_W-1:0] ch, logic [ATTR_W-1:0] attr);
    int unsigned tab_next;
    case (ch)
      CH_LF: begin
        cur_col = 0;
        cur_row++;
      end
      CH_CR: begin
        cur_col = 0;
      end
      CH_TAB: begin
        tab_next = cur_col + TAB_WIDTH;
        cur_col  = tab_next - (tab_next % TAB_WIDTH);
      end
      CH_BS: begin
        if (cur_col > 0) begin
          cur_col--;
          screen_mem[slot_of(cur_row, cur_col)] = {attr, BLANK_CHAR};
        end
      end
      default: begin
        screen_mem[slot_of(cur_row, cur_col)] = {attr, ch};
        cur_col++;
      end
    endcase
    if (cur_col >= COLUMNS) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= ROWS) begin
      for (int unsigned i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
        screen_mem[i] = screen_mem[i + COLUMNS];
      end
      blank_range((ROWS - 1) * COLUMNS, CELLS, attr);
      cur_row = ROWS - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic cursor_report_t predict_report(logic [OP_W-1:0]   op,
                                                    logic [CHAR_W-1:0] ch,
                                                    logic [ATTR_W-1:0] color,
                                                    logic [ROW_W-1:0]  row_raw,
                                                    logic [COL_W-1:0]  col_raw);
    cursor_report_t rep;
    int unsigned    tr;
    int unsigned    tc;
    tr           = (row_raw > ROWS - 1) ? ROWS - 1 : row_raw;
    tc           = (col_raw > COLUMNS - 1) ? COLUMNS - 1 : col_raw;
    rep.cell_val = '0;
    rep.scrolled = 1'b0;
    case (op)
      OP_PUT:        rep.scrolled = put_glyph(ch, active_attr);
      OP_PUT_COLOR:  rep.scrolled = put_glyph(ch, color);
      OP_CLEAR: begin
        blank_range(0, CELLS, active_attr);
        cur_row = 0;
        cur_col = 0;
      end
      OP_SET_CURSOR: begin
        cur_row = tr;
        cur_col = tc;
      end
      OP_READ:       rep.cell_val = screen_mem[slot_of(tr, tc)];
      default: ;
    endcase
    rep.row = ROW_W'(cur_row);
    rep.col = COL_W'(cur_col);
    rep.pos = POS_W'(cur_row * COLUMNS + cur_col);
    return rep;
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
      mismatches_seen++;
    end
  endfunction

  always @(posedge clk) begin
    cursor_report_t want;
    if (!rst_n) begin
      active_attr = RESET_ATTR;
      blank_range(0, CELLS, RESET_ATTR);
      cur_row = 0;
      cur_col = 0;
      expected_reports.delete();
    end else begin
      if (cfg_we) begin
        active_attr = cfg_wdata;
      end
      // results first: a result can never belong to an item taken at the same edge
      if (out_ch.valid && out_ch.ready) begin
        if (expected_reports.size() == 0) begin
          $error("result item with no expectation pending (row %0d col %0d)",
                 out_ch.cursor_row, out_ch.cursor_col);
          mismatches_seen++;
        end else begin
          want = expected_reports.pop_front();
          compare_field("cursor_row", want.row, out_ch.cursor_row);
          compare_field("cursor_col", want.col, out_ch.cursor_col);
          compare_field("cursor_position", want.pos, out_ch.cursor_position);
          compare_field("cell_value", want.cell_val, out_ch.cell_value);
          compare_field("scrolled", want.scrolled, out_ch.scrolled);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_reports.push_back(predict_report(in_ch.operation, in_ch.char_code,
                                                  in_ch.color_override, in_ch.target_row,
                                                  in_ch.target_col));
      end
    end
    mismatch_count  <= mismatches_seen;
    pending_results <= expected_reports.size();
  end

endmodule

FILE: bench/tb_text_console_writer_unit.sv
// Testbench top for the text console writer: clock, reset, stimulus, config and verdict.
`timescale 1ns / 1ps

module tb_text_console_writer_unit;
  import tcw_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  localparam int PHASES         = 5;
  localparam int PHASE_ITEMS    = 310;
  localparam int CALM_FROM      = 100;
  localparam int CALM_LEN       = 60;
  localparam int BACKLOG_AFTER  = 400;
  localparam int BACKLOG_CYCLES = 400;
  localparam int SWEEP_SETTLE   = CELLS + 100;
  localparam int TAIL_CYCLES    = 50;
  localparam int TIMEOUT_NS     = 40_000_000;

  localparam logic [CHAR_W-1:0] CONTROL_CODES [4] = '{CH_BS, CH_TAB, CH_LF, CH_CR};
  localparam logic [ATTR_W-1:0] PHASE_ATTRS [PHASES-1] = '{8'h00, 8'hFF, 8'h1E, 8'h70};

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] color;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } console_cmd_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [ATTR_W-1:0] cfg_wdata;
  int                mismatch_count;
  int                pending_results;
  int                cmds_accepted = 0;
  bit                calm = 1'b0;
  bit                backlog_done = 1'b0;

  tcw_in_if  in_ch ();
  tcw_out_if out_ch ();

  text_console_writer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  tcw_console_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_text_console_writer_unit failed");
    $finish;
  end

  // Mostly back to back, sometimes a few cycles, now and then a long pause.
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic console_cmd_t random_cmd();
    console_cmd_t cmd;
    int unsigned  pick;
    cmd.ch    = CHAR_W'($urandom_range(0, 255));
    cmd.color = ATTR_W'($urandom_range(0, 255));
    cmd.row   = ROW_W'($urandom_range(0, 31));
    cmd.col   = COL_W'($urandom_range(0, 127));
    pick      = $urandom_range(0, 99);
    if (pick < 66 || pick == 99) begin
      cmd.op = ($urandom_range(0, 1) != 0) ? OP_PUT_COLOR : OP_PUT;
      if ($urandom_range(0, 3) == 0) begin
        cmd.ch = CONTROL_CODES[2'($urandom_range(0, 3))];
      end
    end else if (pick < 80) begin
      cmd.op = OP_READ;
    end else if (pick < 93) begin
      cmd.op = OP_SET_CURSOR;
      // lean toward the bottom rows so puts scroll often
      if ($urandom_range(0, 1) != 0) begin
        cmd.row = ROW_W'($urandom_range(ROWS - 2, 31));
      end
    end else if (pick < 98) begin
      cmd.op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    end else begin
      cmd.op = OP_CLEAR;
    end
    return cmd;
  endfunction

  // Called at a rising edge; returns at the edge where the item is taken, or after the idle_after pause when nonzero.
  task automatic send_cmd(console_cmd_t cmd, int unsigned idle_after);
    in_ch.valid          <= 1'b1;
    in_ch.operation      <= cmd.op;
    in_ch.char_code      <= cmd.ch;
    in_ch.color_override <= cmd.color;
    in_ch.target_row     <= cmd.row;
    in_ch.target_col     <= cmd.col;
    do @(posedge clk); while (!in_ch.ready);
    cmds_accepted++;
    if (idle_after > 0) begin
      in_ch.valid <= 1'b0;
      repeat (idle_after) @(posedge clk);
    end
  endtask

  task automatic send_fields(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                             logic [ATTR_W-1:0] color, logic [ROW_W-1:0] row,
                             logic [COL_W-1:0] col);
    send_cmd('{op: op, ch: ch, color: color, row: row, col: col}, pick_idle());
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // Clear and scroll sweeps run on after the last result, so let them finish.
  task automatic reconfigure(logic [ATTR_W-1:0] attr);
    wait_drained();
    repeat (SWEEP_SETTLE) @(posedge clk);
    cfg_wdata <= attr;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Result side: random stalls, one long hold-off to back the block up.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!backlog_done && cmds_accepted >= BACKLOG_AFTER) begin
        out_ch.ready <= 1'b0;
        repeat (BACKLOG_CYCLES) @(posedge clk);
        backlog_done = 1'b1;
      end else if (calm) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_ch.ready <= 1'b0;
        repeat (pick_idle() + 1) @(posedge clk);
      end
    end
  end

  initial begin
    logic [ATTR_W-1:0] phase_attr;
    int unsigned       idle;
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.operation      <= '0;
    in_ch.char_code      <= '0;
    in_ch.color_override <= '0;
    in_ch.target_row     <= '0;
    in_ch.target_col     <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, under the reset attribute
    send_fields(OP_READ, 8'h00, 8'h00, 5'd0, 7'd0);
    send_fields(OP_PUT, 8'h41, 8'h00, 5'd0, 7'd0);
    send_fields(OP_PUT_COLOR, 8'hFF, 8'hFF, 5'd31, 7'd127);
    send_fields(OP_PUT_COLOR, 8'h00, 8'h00, 5'd0, 7'd0);
    send_fields(OP_PUT, CH_TAB, 8'h00, 5'd0, 7'd0);
    send_fields(OP_PUT, CH_BS, 8'h00, 5'd0, 7'd0);
    send_fields(OP_PUT, CH_CR, 8'h00, 5'd0, 7'd0);
    send_fields(OP_PUT, CH_BS, 8'h00, 5'd0, 7'd0);           // backspace at column 0
    send_fields(OP_PUT, CH_LF, 8'h00, 5'd0, 7'd0);
    send_fields(OP_READ, 8'h00, 8'h00, 5'd0, 7'd1);
    send_fields(OP_SET_CURSOR, 8'h00, 8'h00, 5'd31, 7'd127); // saturates to the corner
    send_fields(OP_PUT, 8'h5A, 8'h00, 5'd0, 7'd0);           // wraps and scrolls
    send_fields(OP_READ, 8'h00, 8'h00, 5'd23, 7'd79);
    send_fields(OP_SET_CURSOR, 8'h00, 8'h00, 5'd24, 7'd75);
    send_fields(OP_PUT, CH_TAB, 8'h00, 5'd0, 7'd0);          // tab past the line end
    send_fields(OP_SET_CURSOR, 8'h00, 8'h00, 5'd24, 7'd0);
    send_fields(OP_PUT_COLOR, CH_LF, 8'h5A, 5'd0, 7'd0);     // scroll blank in own color
    send_fields(OP_READ, 8'h00, 8'h00, 5'd31, 7'd127);
    send_fields(OP_PUT_COLOR, CH_BS, 8'hA5, 5'd0, 7'd0);
    for (int k = OP_SPARE_FIRST; k <= OP_SPARE_LAST; k++) begin
      send_fields(OP_W'(k), 8'hFF, 8'hFF, 5'd31, 7'd127);
    end
    send_fields(OP_CLEAR, 8'h00, 8'h00, 5'd0, 7'd0);
    send_fields(OP_READ, 8'h00, 8'h00, 5'd24, 7'd79);
    send_cmd('{op: OP_SET_CURSOR, ch: 8'h00, color: 8'h00, row: 5'd12, col: 7'd40}, 1);

    for (int p = 0; p < PHASES; p++) begin
      phase_attr = (p < PHASES - 1) ? PHASE_ATTRS[p] : ATTR_W'($urandom_range(0, 255));
      reconfigure(phase_attr);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        calm = (n >= CALM_FROM && n < CALM_FROM + CALM_LEN);
        idle = calm ? 0 : pick_idle();
        if (n == PHASE_ITEMS - 1) idle = 1;
        send_cmd(random_cmd(), idle);
      end
      calm = 1'b0;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_text_console_writer_unit passed");
    end else begin
      $display("tb_text_console_writer_unit failed");
    end
    $finish;
  end

endmodule

FILE: text_console_writer_unit.f
rtl/tcw_pkg.sv
rtl/tcw_chan_if.sv
rtl/tcw_put_logic.sv
rtl/text_console_writer_unit.sv
bench/tcw_console_checker.sv
bench/tb_text_console_writer_unit.sv
